// ===== rtl/e2q_pkg.sv =====
// Package: shared types, constants and tables for the Euler-to-quaternion slot writer.
package e2q_pkg;

    localparam int SlotCount        = 128;
    localparam int AngleWidth       = 16;
    localparam int QuatFractionBits = 15;

    localparam int SlotIndexWidth  = 7;
    localparam int SlotOffsetWidth = 12;
    localparam int SlotShift       = 5;
    localparam int AngleInWidth    = 16;
    localparam int QuatWidth       = 16;
    localparam int WordWidth       = 32;

    localparam int CordicSteps = 24;
    localparam int CordicWidth = 34;
    localparam int ZWidth      = 33;
    localparam int ProdWidth   = 32;

    localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;
    localparam logic signed [CordicWidth-1:0] OneQ30     = 34'sd1073741824;
    localparam int QueueDepth = 4;

    typedef logic signed [CordicWidth-1:0] t_cval;
    typedef logic signed [ZWidth-1:0]      t_zval;

    typedef struct packed {
        logic [SlotOffsetWidth-1:0] slot_offset;
        logic                       has_angles;
        logic [AngleInWidth-1:0]    pitch_angle;
        logic [AngleInWidth-1:0]    yaw_angle;
        logic [AngleInWidth-1:0]    roll_angle;
        logic [WordWidth-1:0]       origin_x;
        logic [WordWidth-1:0]       origin_y;
        logic [WordWidth-1:0]       origin_z;
    } t_job;

    typedef struct packed {
        logic [SlotOffsetWidth-1:0] slot_offset;
        logic [QuatWidth-1:0]       quat_x;
        logic [QuatWidth-1:0]       quat_y;
        logic [QuatWidth-1:0]       quat_z;
        logic [QuatWidth-1:0]       quat_w;
        logic [WordWidth-1:0]       trans_x;
        logic [WordWidth-1:0]       trans_y;
        logic [WordWidth-1:0]       trans_z;
    } t_result;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic t_zval atan_turns(input int i);
        case (i)
            0: atan_turns = 33'sh020000000;  1: atan_turns = 33'sh012E4051E;
            2: atan_turns = 33'sh009FB385B;  3: atan_turns = 33'sh0051111D4;
            4: atan_turns = 33'sh0028B0D43;  5: atan_turns = 33'sh00145D7E1;
            6: atan_turns = 33'sh000A2F61E;  7: atan_turns = 33'sh000517C55;
            8: atan_turns = 33'sh00028BE53;  9: atan_turns = 33'sh000145F2F;
            10: atan_turns = 33'sh0000A2F98; 11: atan_turns = 33'sh0000517CC;
            12: atan_turns = 33'sh000028BE6; 13: atan_turns = 33'sh0000145F3;
            14: atan_turns = 33'sh00000A2FA; 15: atan_turns = 33'sh00000517D;
            16: atan_turns = 33'sh0000028BE; 17: atan_turns = 33'sh00000145F;
            18: atan_turns = 33'sh000000A30; 19: atan_turns = 33'sh000000518;
            20: atan_turns = 33'sh00000028C; 21: atan_turns = 33'sh000000146;
            22: atan_turns = 33'sh0000000A3; 23: atan_turns = 33'sh000000051;
            default: atan_turns = '0;
        endcase
    endfunction

    // Q30 product rounded: (a*b + 2^29) floored by 2^30
    function automatic t_cval mul_q30(input t_cval a, input t_cval b);
        logic signed [2*CordicWidth-1:0] p;
        begin
            p = a * b + (68'sd1 <<< 29);
            mul_q30 = t_cval'(p >>> 30);
        end
    endfunction

    // Q30 to output fraction bits, rounded and saturated
    function automatic logic [QuatWidth-1:0] to_out(input t_cval v, input int fb);
        logic signed [CordicWidth:0] r;
        begin
            r = (fb < 30) ? ((CordicWidth+1)'(v) + ((CordicWidth+1)'(1) <<< (29 - fb)))
                            >>> (30 - fb) : (CordicWidth+1)'(v);
            if (r > 35'sd32767)       to_out = 16'h7FFF;
            else if (r < -35'sd32768) to_out = 16'h8000;
            else                      to_out = r[QuatWidth-1:0];
        end
    endfunction

endpackage

// ===== rtl/e2q_stream_if.sv =====
// Interface: valid/ready stream channel carrying one word of a given type.
interface e2q_stream_if #(parameter type t_word = logic) ();
    logic  valid;
    logic  ready;
    t_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/euler_to_quaternion_slot_write.sv =====
// Top level: Euler angle to quaternion slot writer. Takes one word per cycle while the
// job queue has room and presents one result word per input after it passes the job
// queue, the 24-step CORDIC pipeline with its load stage, then pair product, roll
// product and rounding stages; a four-entry job queue sits between the input front
// end and the arithmetic back end, and the output register holds a result while the
// downstream side stalls, which stalls the whole pipeline.
module euler_to_quaternion_slot_write #(
    parameter int SLOT_COUNT         = e2q_pkg::SlotCount,
    parameter int ANGLE_WIDTH        = e2q_pkg::AngleWidth,
    parameter int QUAT_FRACTION_BITS = e2q_pkg::QuatFractionBits
) (
    input  logic i_clk,
    input  logic i_rst_n,
    e2q_stream_if.sink   i_in,
    e2q_stream_if.source o_out
);
    import e2q_pkg::*;

    logic w_qvalid, w_qready;
    t_job w_job;
    t_job w_in;
    t_result w_res;

    assign w_in = i_in.data;

    e2q_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_slot_index(w_in.slot_offset[SlotIndexWidth-1:0]),
        .i_has_angles(w_in.has_angles),
        .i_pitch_angle(w_in.pitch_angle), .i_yaw_angle(w_in.yaw_angle),
        .i_roll_angle(w_in.roll_angle),
        .i_origin_x(w_in.origin_x), .i_origin_y(w_in.origin_y),
        .i_origin_z(w_in.origin_z),
        .o_valid(w_qvalid), .i_ready(w_qready), .o_job(w_job)
    );

    e2q_back #(.ANGLE_WIDTH(ANGLE_WIDTH), .QUAT_FRACTION_BITS(QUAT_FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qvalid), .o_ready(w_qready), .i_job(w_job),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_result(w_res)
    );

    assign o_out.data = w_res;
endmodule

// ===== rtl/e2q_front.sv =====
// Front end: accepts input words, computes the slot offset and queues jobs.
module e2q_front #(
    parameter int SLOT_COUNT = e2q_pkg::SlotCount
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [e2q_pkg::SlotIndexWidth-1:0]  i_slot_index,
    input  logic                                i_has_angles,
    input  logic [e2q_pkg::AngleInWidth-1:0]    i_pitch_angle,
    input  logic [e2q_pkg::AngleInWidth-1:0]    i_yaw_angle,
    input  logic [e2q_pkg::AngleInWidth-1:0]    i_roll_angle,
    input  logic [e2q_pkg::WordWidth-1:0]       i_origin_x,
    input  logic [e2q_pkg::WordWidth-1:0]       i_origin_y,
    input  logic [e2q_pkg::WordWidth-1:0]       i_origin_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output e2q_pkg::t_job                       o_job
);
    import e2q_pkg::*;
    localparam int PtrW = $clog2(QueueDepth);
    localparam int ModWidth = SlotIndexWidth + 11;

    t_job               r_mem [QueueDepth];
    logic [PtrW-1:0]    r_wr, r_rd;
    logic [PtrW:0]      r_cnt;
    t_job               n_job;
    logic [SlotIndexWidth+SlotShift-1:0] w_idx;
    logic [ModWidth-1:0] w_rem;
    logic               w_push, w_pop;

    // Slot index wraps modulo the slot count (compare and subtract), then scales
    always_comb begin
        w_rem = ModWidth'(i_slot_index);
        for (int k = SlotIndexWidth - 1; k >= 0; k--) begin
            if (w_rem >= (ModWidth'(SLOT_COUNT) << k))
                w_rem = w_rem - (ModWidth'(SLOT_COUNT) << k);
        end
        w_idx = {w_rem[SlotIndexWidth-1:0], SlotShift'(0)};
        n_job.slot_offset = w_idx[SlotOffsetWidth-1:0];
        n_job.has_angles  = i_has_angles;
        n_job.pitch_angle = i_pitch_angle;
        n_job.yaw_angle   = i_yaw_angle;
        n_job.roll_angle  = i_roll_angle;
        n_job.origin_x    = i_origin_x;
        n_job.origin_y    = i_origin_y;
        n_job.origin_z    = i_origin_z;
    end

    assign o_ready = (r_cnt != (PtrW+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Job queue
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= n_job;
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end
endmodule

// ===== rtl/e2q_back.sv =====
// Back end: pipelined CORDIC half-angle sine/cosine and quaternion product.
module e2q_back #(
    parameter int ANGLE_WIDTH        = e2q_pkg::AngleWidth,
    parameter int QUAT_FRACTION_BITS = e2q_pkg::QuatFractionBits
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  e2q_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output e2q_pkg::t_result o_result
);
    import e2q_pkg::*;
    localparam int Stages = CordicSteps + 3;  // init, 24 steps, pairs, products
    localparam int Lanes = 3;                 // 0 yaw, 1 pitch, 2 roll

    // Skid output: the pipeline advances whenever the output slot is free
    logic r_ovalid;
    logic w_adv;
    assign w_adv   = !r_ovalid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_ovalid;

    logic  r_v    [Stages];
    t_job  r_j    [Stages];
    logic  r_up   [CordicSteps+1][Lanes];
    t_cval r_x    [CordicSteps+1][Lanes];
    t_cval r_y    [CordicSteps+1][Lanes];
    t_zval r_z    [CordicSteps+1][Lanes];
    t_cval r_a, r_b, r_c, r_d, r_sx, r_cx;
    t_cval r_p [8];
    t_result r_out;

    logic [ANGLE_WIDTH-1:0] w_ang [Lanes];
    assign w_ang[0] = ANGLE_WIDTH'(i_job.yaw_angle);
    assign w_ang[1] = ANGLE_WIDTH'(i_job.pitch_angle);
    assign w_ang[2] = ANGLE_WIDTH'(i_job.roll_angle);

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < Stages; s++) r_v[s] <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < Stages; s++) r_v[s] <= r_v[s-1];
            r_ovalid <= r_v[Stages-1];
        end
    end

    // CORDIC lanes: stage 0 loads, stage i+1 holds the result of step i
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j[0] <= i_job;
            for (int s = 1; s < Stages; s++) r_j[s] <= r_j[s-1];
            for (int l = 0; l < Lanes; l++) begin
                r_up[0][l] <= w_ang[l][ANGLE_WIDTH-1];
                r_x[0][l]  <= CordicGain;
                r_y[0][l]  <= '0;
                r_z[0][l]  <= t_zval'({w_ang[l][ANGLE_WIDTH-2:0], (31-ANGLE_WIDTH)'(0)});
                for (int i = 0; i < CordicSteps; i++) begin
                    r_up[i+1][l] <= r_up[i][l];
                    if (!r_z[i][l][ZWidth-1]) begin
                        r_x[i+1][l] <= r_x[i][l] - (r_y[i][l] >>> i);
                        r_y[i+1][l] <= r_y[i][l] + (r_x[i][l] >>> i);
                        r_z[i+1][l] <= r_z[i][l] - atan_turns(i);
                    end else begin
                        r_x[i+1][l] <= r_x[i][l] + (r_y[i][l] >>> i);
                        r_y[i+1][l] <= r_y[i][l] - (r_x[i][l] >>> i);
                        r_z[i+1][l] <= r_z[i][l] + atan_turns(i);
                    end
                end
            end
        end
    end

    // Clamp and quadrant fold
    t_cval w_s [Lanes], w_c [Lanes];
    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            t_cval cx, cy;
            cx = r_x[CordicSteps][l];
            cy = r_y[CordicSteps][l];
            if (cx > OneQ30) cx = OneQ30; else if (cx < -OneQ30) cx = -OneQ30;
            if (cy > OneQ30) cy = OneQ30; else if (cy < -OneQ30) cy = -OneQ30;
            if (r_up[CordicSteps][l]) begin
                w_s[l] = cx; w_c[l] = -cy;
            end else begin
                w_s[l] = cy; w_c[l] = cx;
            end
        end
    end

    // Pair products, then roll products, then sums and output conversion
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a  <= mul_q30(w_c[0], w_c[1]);
            r_b  <= mul_q30(w_s[0], w_s[1]);
            r_c  <= mul_q30(w_c[0], w_s[1]);
            r_d  <= mul_q30(w_s[0], w_c[1]);
            r_sx <= w_s[2];
            r_cx <= w_c[2];
            r_p[0] <= mul_q30(r_a, r_sx); r_p[1] <= mul_q30(r_b, r_cx);
            r_p[2] <= mul_q30(r_c, r_cx); r_p[3] <= mul_q30(r_d, r_sx);
            r_p[4] <= mul_q30(r_d, r_cx); r_p[5] <= mul_q30(r_c, r_sx);
            r_p[6] <= mul_q30(r_a, r_cx); r_p[7] <= mul_q30(r_b, r_sx);
            r_out.slot_offset <= r_j[Stages-1].slot_offset;
            r_out.trans_x <= r_j[Stages-1].origin_x;
            r_out.trans_y <= r_j[Stages-1].origin_y;
            r_out.trans_z <= r_j[Stages-1].origin_z;
            if (r_j[Stages-1].has_angles) begin
                r_out.quat_x <= to_out(r_p[0] - r_p[1], QUAT_FRACTION_BITS);
                r_out.quat_y <= to_out(r_p[2] + r_p[3], QUAT_FRACTION_BITS);
                r_out.quat_z <= to_out(r_p[4] - r_p[5], QUAT_FRACTION_BITS);
                r_out.quat_w <= to_out(r_p[6] + r_p[7], QUAT_FRACTION_BITS);
            end else begin
                r_out.quat_x <= '0;
                r_out.quat_y <= '0;
                r_out.quat_z <= '0;
                r_out.quat_w <= to_out(OneQ30, QUAT_FRACTION_BITS);
            end
        end
    end
    assign o_result = r_out;
endmodule

// ===== rtl/e2q_checker.sv =====
// Checker: port-level properties of the slot writer, bound to the top level.
module e2q_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input e2q_pkg::t_result  out_data
);
    import e2q_pkg::*;

    // Stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // Slot offset is always a multiple of the slot stride
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.slot_offset[SlotShift-1:0] == '0)
        else $error("slot offset misaligned");

    // Nothing emerges right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid after reset");

    // An idle block stays ready
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid && $past(!in_valid) && $past(!out_valid) && $past(in_ready) |-> in_ready)
        else $error("input stalled while idle");
endmodule

bind euler_to_quaternion_slot_write e2q_checker u_e2q_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_data(o_out.data)
);
